// File: design/bmorph_pkg.sv
`default_nettype none

package bmorph_pkg;

	// Fixed widths of the register fields and the result count.
	localparam int SIZE_W  = 13;
	localparam int COUNT_W = 25;

	// Configuration port geometry: three 32-bit registers at 0x0, 0x4, 0x8.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Default frame limits.
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam logic [SIZE_W-1:0]  SIZE_RESET = 13'd4096;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

	// Window shift mask: keeps the two older columns of each row.
	localparam logic [8:0] SHIFT_KEEP = 9'h1B6;

	localparam logic MODE_ERODE  = 1'b0;
	localparam logic MODE_DILATE = 1'b1;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic              mode;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic emit;
		logic last;
		logic border;
	} item_flags_t;

endpackage

`default_nettype wire

// File: design/binary_morphology_3x3_top.sv
`default_nettype none

// 3x3 binary erosion (morph_mode 0) or dilation (morph_mode 1) of a mask that
// arrives one pixel per beat in raster order. The block sustains one pixel per
// clock while the output is not stalled: each beat reads the two earlier rows
// of its column from a single two-bit-wide line memory in the cycle it is
// accepted and writes the shifted column back when it leaves the window stage,
// so the line memory port pair sets the rate. A result beat leaves the window
// stage into the output register at the same edge that writes the column back,
// and results lag the input by frame_width+1 beats; after the frame the host
// sends frame_width+1 beats with drain set to push out the trailing results.
// Border pixels always give zero. ones_count is the running count of ones
// in the frame, saturating, and is final on the beat marked frame_last. After
// reset a sweep zeroes the line memory and no pixel is accepted until it ends;
// register writes are taken throughout. Registers lie at 0x0 (mode), 0x4
// (width) and 0x8 (height) and should be written between beats.
module binary_morphology_3x3_top
	import bmorph_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  pixel_in,
	input  wire logic                  drain,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       pixel_out,
	output logic                       frame_last,
	output logic      [COUNT_W-1:0]    ones_count
);

	localparam int AW = $clog2(MAX_WIDTH);

	cfg_t          cfg;
	item_flags_t   flags;
	logic [AW-1:0] col;
	logic          clr_busy;
	logic [AW-1:0] clr_addr;
	logic          accept;

	// Line memory entry: bit 1 holds the previous row, bit 0 the row before.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [1:0]    ram_wdata;
	logic [1:0]    ram_rdata;

	// Window stage.
	logic          s1_valid;
	logic          fresh_s1;
	logic          fwd_s1;
	logic [1:0]    fwd_data_s1;
	logic [AW-1:0] col_s1;
	logic          px_s1;
	item_flags_t   flags_s1;
	logic [1:0]    hold_q;
	logic [1:0]    rd_s1;
	logic          s1_go;

	logic [8:0]         window_q;
	logic [8:0]         win_next;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] cnt_inc;
	logic               res;

	logic               out_valid_q;
	logic               pixel_out_q;
	logic               frame_last_q;
	logic [COUNT_W-1:0] ones_count_q;

	bmorph_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bmorph_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.accept   (accept),
		.col      (col),
		.flags    (flags),
		.clr_busy (clr_busy),
		.clr_addr (clr_addr)
	);

	bmorph_ram #(
		.WIDTH (2),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (col),
		.rdata (ram_rdata)
	);

	// The window stage moves on unless its result has nowhere to go.
	assign s1_go    = s1_valid && (!flags_s1.emit || !out_valid_q || out_ready);
	assign in_ready = !clr_busy && (!s1_valid || s1_go);
	assign accept   = in_valid && in_ready;

	// Memory data is only fresh in the first cycle of the stage. When the
	// previous beat writes the same column at the edge of this read (a
	// one-pixel-wide frame, or the beat after a frame's last beat), the written
	// entry is forwarded instead. A stalled beat keeps its copy in hold_q.
	assign rd_s1 = fresh_s1 ? (fwd_s1 ? fwd_data_s1 : ram_rdata) : hold_q;

	// New column: top row from two lines back, middle from one, pixel newest.
	assign win_next = ((window_q << 1) & SHIFT_KEEP)
		| {2'b00, rd_s1[0], 2'b00, rd_s1[1], 2'b00, px_s1};

	assign res = !flags_s1.border
		&& ((cfg.mode == MODE_DILATE) ? (|win_next) : (&win_next));

	assign cnt_inc = (res && (cnt_q != COUNT_MAX)) ? cnt_q + COUNT_W'(1) : cnt_q;

	// The clearing sweep owns the write port until it is done.
	always_comb begin
		if (clr_busy) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr;
			ram_wdata = 2'b00;
		end else begin
			ram_we    = s1_go;
			ram_waddr = col_s1;
			ram_wdata = {px_s1, rd_s1[1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			fresh_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			fresh_s1 <= accept;
			if (accept) begin
				s1_valid <= 1'b1;
				fwd_s1   <= s1_go && (col_s1 == col);
			end else if (s1_go) begin
				s1_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= rd_s1;
		if (accept) begin
			col_s1      <= col;
			px_s1       <= drain ? 1'b0 : pixel_in;
			flags_s1    <= flags;
			fwd_data_s1 <= {px_s1, rd_s1[1]};
		end
	end

	// Window and count restart after the last result of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			cnt_q    <= '0;
		end else if (s1_go) begin
			if (flags_s1.last) begin
				window_q <= '0;
				cnt_q    <= '0;
			end else begin
				window_q <= win_next;
				if (flags_s1.emit) begin
					cnt_q <= cnt_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && flags_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && flags_s1.emit) begin
			pixel_out_q  <= res;
			frame_last_q <= flags_s1.last;
			ones_count_q <= cnt_inc;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign frame_last = frame_last_q;
	assign ones_count = ones_count_q;

`ifndef SYNTH
	// No beat may be in the window stage while the sweep owns the memory.
	a_no_beat_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s1_valid)
		else $error("window stage busy during line memory clear");

	// The window stage holds only because the output register is blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_go) |-> (out_valid_q && !out_ready))
		else $error("window stage stalled without output back-pressure");

	// Back-to-back hits on one column only occur at column zero.
	a_fwd_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && fwd_s1) |-> (col_s1 == '0))
		else $error("forwarding on a column other than zero");

	// A stalled stage must have captured its memory data the cycle before.
	a_hold_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !fresh_s1) |-> $past(s1_valid))
		else $error("window stage lost its memory data");
`endif

endmodule

`default_nettype wire

// File: design/bmorph_ram.sv
`default_nettype none

module bmorph_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/bmorph_cfg.sv
`default_nettype none

module bmorph_cfg
	import bmorph_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic              mode_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	reg_idx_t          idx;
	logic              wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_ERODE;
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_MODE:   mode_q   <= pwdata[0];
				REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:   prdata = {{(APB_DATA_W-1){1'b0}}, mode_q};
			REG_WIDTH:  prdata = {{(APB_DATA_W-SIZE_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(APB_DATA_W-SIZE_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.mode   = mode_q;
	assign cfg.width  = width_q;
	assign cfg.height = height_q;

endmodule

`default_nettype wire

// File: design/bmorph_ctrl.sv
`default_nettype none

module bmorph_ctrl
	import bmorph_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cfg_t                         cfg,
	input  wire logic                         accept,
	output logic      [$clog2(MAX_WIDTH)-1:0] col,
	output item_flags_t                       flags,
	output logic                              clr_busy,
	output logic      [$clog2(MAX_WIDTH)-1:0] clr_addr
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = AW + 1;
	localparam int RW = $clog2(MAX_HEIGHT + 3);
	localparam int KW = (SIZE_W > CW) ? SIZE_W : CW;
	localparam int KH = (SIZE_W > RW) ? SIZE_W : RW;

	logic [KW-1:0] w_ext, w_cl;
	logic [KH-1:0] h_ext, h_cl;
	logic [CW-1:0] w;
	logic [RW-1:0] h;
	logic [AW-1:0] col_q, c;
	logic [RW-1:0] row_q, r;
	logic [CW-1:0] c_inc;
	logic          wrap_pre, wrap_post;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// Sizes are clamped to 1..MAX when used; a zero acts as one.
	always_comb begin
		w_ext = KW'(cfg.width);
		h_ext = KH'(cfg.height);
		if (w_ext == '0) begin
			w_cl = KW'(1);
		end else if (w_ext > KW'(MAX_WIDTH)) begin
			w_cl = KW'(MAX_WIDTH);
		end else begin
			w_cl = w_ext;
		end
		if (h_ext == '0) begin
			h_cl = KH'(1);
		end else if (h_ext > KH'(MAX_HEIGHT)) begin
			h_cl = KH'(MAX_HEIGHT);
		end else begin
			h_cl = h_ext;
		end
		w = w_cl[CW-1:0];
		h = h_cl[RW-1:0];
	end

	// A column left at or past a narrowed width wraps before use.
	always_comb begin
		wrap_pre  = {1'b0, col_q} >= w;
		c         = wrap_pre ? '0 : col_q;
		r         = wrap_pre ? row_q + RW'(1) : row_q;
		c_inc     = {1'b0, c} + CW'(1);
		wrap_post = c_inc >= w;
	end

	assign col          = c;
	assign flags.emit   = (r >= RW'(2)) || ((r == RW'(1)) && (c != '0));
	assign flags.last   = r > h;
	assign flags.border = (c == '0) || (c == AW'(1)) || (r <= RW'(1)) || (r >= h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (flags.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap_post) begin
				col_q <= '0;
				row_q <= r + RW'(1);
			end else begin
				col_q <= c_inc[AW-1:0];
				row_q <= r;
			end
		end
	end

	// Sweep that zeroes the line memory once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	assign clr_busy = clr_busy_q;
	assign clr_addr = clr_addr_q;

endmodule

`default_nettype wire
